// File: design/assert_macros.svh
// Assertion macros used by the checker file of the design.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AST_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define AST_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/hvt_pkg.sv
// Package of the histogram valley threshold block: sizes, payload types,
// and the control struct for the peak tracker. No dependencies.
package hvt_pkg;

   localparam int HVT_COUNT_WIDTH = 22;
   localparam int HVT_BIN_COUNT   = 256;
   localparam int PIX_W           = 8;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_value;
      logic             in_region;
      logic             last_pixel;
   } hvt_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] threshold_level;
      logic             too_few_peaks;
   } hvt_rsp_type;

   // Control from the sequencer to the peak tracker, one per scan cycle.
   typedef struct packed {
      logic             clear;   // start of a scan: drop old peaks
      logic             shift;   // a bin count arrives: advance the window
      logic             eval;    // window center is a candidate bin
      logic [PIX_W-1:0] center;  // bin index of the window center
   } hvt_pk_ctl_type;

endpackage

// File: design/hvt_bin_mem.sv
// Histogram bin store: one-port-read, one-port-write synchronous memory
// with a valid bit per bin so a frame clear resets only the valid bits. Uses hvt_pkg.
module hvt_bin_mem #(
   parameter int COUNT_WIDTH = hvt_pkg::HVT_COUNT_WIDTH,
   parameter int BIN_COUNT   = hvt_pkg::HVT_BIN_COUNT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear_all,
   input  logic                     rd_en,
   input  logic [hvt_pkg::PIX_W-1:0] rd_addr,
   input  logic                     wr_en,
   input  logic [hvt_pkg::PIX_W-1:0] wr_addr,
   input  logic [COUNT_WIDTH-1:0]   wr_data,
   output logic [COUNT_WIDTH-1:0]   rd_data
);
   import hvt_pkg::*;

   logic [COUNT_WIDTH-1:0] mem_ff [BIN_COUNT];
   logic [BIN_COUNT-1:0]   bin_vld_ff;
   logic [COUNT_WIDTH-1:0] rd_cnt_ff;
   logic                   rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_cnt_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         bin_vld_ff <= '0;
      end else if (wr_en) begin
         bin_vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else if (rd_en) begin
         rd_vld_ff <= bin_vld_ff[rd_addr];
      end
   end

   // A bin never written since the last clear reads as zero.
   assign rd_data = rd_vld_ff ? rd_cnt_ff : '0;

endmodule

// File: design/hvt_peak_track.sv
// Peak tracker: three-bin sliding window over the scanned counts, keeps the
// two largest strict local peaks. Uses hvt_pkg.
module hvt_peak_track #(
   parameter int COUNT_WIDTH = hvt_pkg::HVT_COUNT_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  hvt_pkg::hvt_pk_ctl_type   ctl,
   input  logic [COUNT_WIDTH-1:0]    din,
   output logic [hvt_pkg::PIX_W-1:0] top_bin,
   output logic [hvt_pkg::PIX_W-1:0] second_bin,
   output logic [1:0]                peaks_seen
);
   import hvt_pkg::*;

   logic [COUNT_WIDTH-1:0] w0_ff, w0_in, w1_ff, w1_in;
   logic [COUNT_WIDTH-1:0] top_cnt_ff, top_cnt_in, sec_cnt_ff, sec_cnt_in;
   logic [PIX_W-1:0]       top_bin_ff, top_bin_in, sec_bin_ff, sec_bin_in;
   logic [1:0]             seen_ff, seen_in;
   logic                   is_peak;

   assign is_peak = ctl.eval && (w1_ff > w0_ff) && (w1_ff > din);

   always_comb begin
      w0_in      = w0_ff;
      w1_in      = w1_ff;
      top_cnt_in = top_cnt_ff;
      sec_cnt_in = sec_cnt_ff;
      top_bin_in = top_bin_ff;
      sec_bin_in = sec_bin_ff;
      seen_in    = seen_ff;
      if (ctl.clear) begin
         top_bin_in = '0;
         sec_bin_in = '0;
         seen_in    = 2'd0;
      end else begin
         if (ctl.shift) begin
            w0_in = w1_ff;
            w1_in = din;
         end
         if (is_peak) begin
            // Replace only on a strictly larger count: ties stay with the lower bin.
            priority if (seen_ff == 2'd0) begin
               top_bin_in = ctl.center;
               top_cnt_in = w1_ff;
               seen_in    = 2'd1;
            end else if (w1_ff > top_cnt_ff) begin
               sec_bin_in = top_bin_ff;
               sec_cnt_in = top_cnt_ff;
               top_bin_in = ctl.center;
               top_cnt_in = w1_ff;
               seen_in    = 2'd2;
            end else if (seen_ff == 2'd1 || w1_ff > sec_cnt_ff) begin
               sec_bin_in = ctl.center;
               sec_cnt_in = w1_ff;
               seen_in    = 2'd2;
            end else begin
               // Weaker than both kept peaks: hold them.
               seen_in = seen_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= 2'd0;
         top_bin_ff <= '0;
         sec_bin_ff <= '0;
      end else begin
         seen_ff    <= seen_in;
         top_bin_ff <= top_bin_in;
         sec_bin_ff <= sec_bin_in;
      end
   end

   always_ff @(posedge clock) begin
      w0_ff      <= w0_in;
      w1_ff      <= w1_in;
      top_cnt_ff <= top_cnt_in;
      sec_cnt_ff <= sec_cnt_in;
   end

   assign top_bin    = top_bin_ff;
   assign second_bin = sec_bin_ff;
   assign peaks_seen = seen_ff;

endmodule

// File: design/histogram_valley_threshold.sv
// Histogram valley threshold, top level.
// Uses hvt_pkg, hvt_bin_mem and hvt_peak_track.
//
// Usage:
//  - Request channel (req_valid/req_ready/req_data): one pixel per request with
//    a region bit and a last-pixel mark. While a frame streams in, req_ready
//    stays high and one pixel is taken every cycle; a pixel inside the region
//    and not zero bumps its bin (saturating at the top of the count range).
//  - Each bin update is a read-modify-write of the bin memory (read, then write);
//    back-to-back pixels of the same bin take the count from the write of the
//    cycle before (forwarding), so no stall is needed.
//  - After the last pixel, req_ready drops: a drain state, a peak scan over all
//    bins, a setup state, a valley search from the lower peak to bin 255 (skipped
//    with too few peaks) and a state to post the result; both scans use the
//    single bin memory read port.
//  - Response channel (rsp_valid/rsp_ready/rsp_data): one response per frame,
//    held in an output register. If the receiver stalls, the next frame is
//    still accepted; only the next frame end waits for the register to free.
//  - Reset (synchronous, active high) empties the histogram, clears the peak
//    state and drops any pending response. The histogram is emptied as each
//    response is posted, through per-bin valid bits.
module histogram_valley_threshold #(
   parameter int COUNT_WIDTH = hvt_pkg::HVT_COUNT_WIDTH,
   parameter int BIN_COUNT   = hvt_pkg::HVT_BIN_COUNT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hvt_pkg::hvt_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hvt_pkg::hvt_rsp_type rsp_data
);
   import hvt_pkg::*;

   localparam int ISS_W = PIX_W + 1;
   localparam logic [PIX_W-1:0] LAST_BIN = PIX_W'(BIN_COUNT - 1);
   localparam logic [PIX_W-1:0] FIRST_CENTER_TAG = PIX_W'(2);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam logic [2:0] ST_ACC    = 3'd0;  // take pixels
   localparam logic [2:0] ST_DRAIN  = 3'd1;  // finish last bin update
   localparam logic [2:0] ST_SCAN   = 3'd2;  // peak scan over all bins
   localparam logic [2:0] ST_VINIT  = 3'd3;  // choose lower peak
   localparam logic [2:0] ST_VALLEY = 3'd4;  // minimum search
   localparam logic [2:0] ST_DONE   = 3'd5;  // post response

   logic [2:0]             state_ff, state_in;
   logic [ISS_W-1:0]       iss_ff, iss_in;
   logic                   tag_vld_ff, tag_vld_in;
   logic [PIX_W-1:0]       tag_ff, tag_in;
   logic                   b_vld_ff, b_vld_in;
   logic [PIX_W-1:0]       b_addr_ff, b_addr_in;
   logic                   lw_vld_ff, lw_vld_in;
   logic [PIX_W-1:0]       lw_addr_ff, lw_addr_in;
   logic [COUNT_WIDTH-1:0] lw_cnt_ff, lw_cnt_in;
   logic [PIX_W-1:0]       best_bin_ff, best_bin_in;
   logic [COUNT_WIDTH-1:0] best_cnt_ff, best_cnt_in;
   logic                   v_first_ff, v_first_in;
   logic [PIX_W-1:0]       res_level_ff, res_level_in;
   logic                   res_few_ff, res_few_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   hvt_rsp_type            rsp_data_ff, rsp_data_in;

   logic                   accept, count_it;
   logic                   rd_en;
   logic [PIX_W-1:0]       rd_addr;
   logic [COUNT_WIDTH-1:0] rd_data, cur_cnt, inc_cnt;
   logic                   clear_all;
   hvt_pk_ctl_type         pk_ctl;
   logic [PIX_W-1:0]       top_bin, second_bin, lower_bin;
   logic [1:0]             peaks_seen;

   assign req_ready = (state_ff == ST_ACC);
   assign accept    = req_valid && req_ready;
   assign count_it  = req_data.in_region && (req_data.pixel_value != '0);

   // Memory read port: pixels while streaming, sweep counter while scanning.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = req_data.pixel_value;
      unique case (state_ff)
         ST_ACC: begin
            rd_en   = accept && count_it;
            rd_addr = req_data.pixel_value;
         end
         ST_SCAN, ST_VALLEY: begin
            rd_en   = !iss_ff[ISS_W-1];
            rd_addr = iss_ff[PIX_W-1:0];
         end
         default: begin
            rd_en   = 1'b0;
            rd_addr = req_data.pixel_value;
         end
      endcase
   end

   // Take the count from last cycle's write when the read raced it.
   assign cur_cnt = (lw_vld_ff && lw_addr_ff == b_addr_ff) ? lw_cnt_ff : rd_data;
   assign inc_cnt = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);

   assign lower_bin = (top_bin < second_bin) ? top_bin : second_bin;

   assign pk_ctl.clear  = (state_ff == ST_DRAIN);
   assign pk_ctl.shift  = (state_ff == ST_SCAN) && tag_vld_ff;
   assign pk_ctl.eval   = (state_ff == ST_SCAN) && tag_vld_ff && (tag_ff >= FIRST_CENTER_TAG);
   assign pk_ctl.center = tag_ff - PIX_W'(1);

   always_comb begin
      state_in     = state_ff;
      iss_in       = iss_ff;
      tag_vld_in   = rd_en && (state_ff == ST_SCAN || state_ff == ST_VALLEY);
      tag_in       = rd_addr;
      b_vld_in     = accept && count_it;
      b_addr_in    = req_data.pixel_value;
      lw_vld_in    = b_vld_ff;
      lw_addr_in   = b_addr_ff;
      lw_cnt_in    = inc_cnt;
      best_bin_in  = best_bin_ff;
      best_cnt_in  = best_cnt_ff;
      v_first_in   = v_first_ff;
      res_level_in = res_level_ff;
      res_few_in   = res_few_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      clear_all    = 1'b0;
      if (!iss_ff[ISS_W-1] && (state_ff == ST_SCAN || state_ff == ST_VALLEY)) begin
         iss_in = iss_ff + ISS_W'(1);
      end
      unique case (state_ff)
         ST_ACC: begin
            if (accept && req_data.last_pixel) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            iss_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (tag_vld_ff && tag_ff == LAST_BIN) begin
               state_in = ST_VINIT;
            end
         end
         ST_VINIT: begin
            if (peaks_seen < 2'd2) begin
               res_level_in = '0;
               res_few_in   = 1'b1;
               state_in     = ST_DONE;
            end else begin
               iss_in     = {1'b0, lower_bin};
               v_first_in = 1'b1;
               state_in   = ST_VALLEY;
            end
         end
         ST_VALLEY: begin
            if (tag_vld_ff) begin
               // Strict compare: the first minimum wins.
               if (v_first_ff || rd_data < best_cnt_ff) begin
                  best_bin_in = tag_ff;
                  best_cnt_in = rd_data;
               end
               v_first_in = 1'b0;
               if (tag_ff == LAST_BIN) begin
                  res_level_in = (v_first_ff || rd_data < best_cnt_ff) ? tag_ff : best_bin_ff;
                  res_few_in   = 1'b0;
                  state_in     = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.threshold_level = res_level_ff;
               rsp_data_in.too_few_peaks   = res_few_ff;
               clear_all                   = 1'b1;
               state_in                    = ST_ACC;
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         tag_vld_ff   <= 1'b0;
         b_vld_ff     <= 1'b0;
         lw_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tag_vld_ff   <= tag_vld_in;
         b_vld_ff     <= b_vld_in;
         lw_vld_ff    <= lw_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff       <= iss_in;
      tag_ff       <= tag_in;
      b_addr_ff    <= b_addr_in;
      lw_addr_ff   <= lw_addr_in;
      lw_cnt_ff    <= lw_cnt_in;
      best_bin_ff  <= best_bin_in;
      best_cnt_ff  <= best_cnt_in;
      v_first_ff   <= v_first_in;
      res_level_ff <= res_level_in;
      res_few_ff   <= res_few_in;
      rsp_data_ff  <= rsp_data_in;
   end

   hvt_bin_mem #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .BIN_COUNT   (BIN_COUNT)
   ) u_mem (
      .clock     (clock),
      .reset     (reset),
      .clear_all (clear_all),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .wr_en     (b_vld_ff),
      .wr_addr   (b_addr_ff),
      .wr_data   (inc_cnt),
      .rd_data   (rd_data)
   );

   hvt_peak_track #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_peak (
      .clock      (clock),
      .reset      (reset),
      .ctl        (pk_ctl),
      .din        (rd_data),
      .top_bin    (top_bin),
      .second_bin (second_bin),
      .peaks_seen (peaks_seen)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: design/hvt_checker.sv
// Port-level checker for the histogram valley threshold block, with its bind.
// Uses hvt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hvt_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input hvt_pkg::hvt_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input hvt_pkg::hvt_rsp_type rsp_data
);
   import hvt_pkg::*;

   `AST_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
   `AST_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data), "response changed while stalled")
   `AST_IMPLY(a_few_zero, clock, reset, rsp_valid && rsp_data.too_few_peaks, rsp_data.threshold_level == '0, "error response with nonzero level")
   `AST_IMPLY(a_valley_nonzero, clock, reset, rsp_valid && !rsp_data.too_few_peaks, rsp_data.threshold_level != '0, "valley below lowest peak bin")
   `AST_NEXT(a_last_stall, clock, reset, req_valid && req_ready && req_data.last_pixel, !req_ready, "request taken during frame-end scan")

endmodule

bind histogram_valley_threshold hvt_checker u_hvt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
